[hw/rtl/phbo_pkg.sv]
package phbo_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef logic [1:0] level_t;

	localparam level_t LVL_HIZ  = 2'd0;
	localparam level_t LVL_LOW  = 2'd1;
	localparam level_t LVL_HIGH = 2'd2;

	localparam logic [1:0] TYPE_OFF         = 2'd0;
	localparam logic [1:0] TYPE_PUSH_PULL   = 2'd1;
	localparam logic [1:0] TYPE_OPEN_DRAIN  = 2'd2;
	localparam logic [1:0] TYPE_OPEN_SOURCE = 2'd3;

	localparam logic [2:0] REG_OUTPUT_MODE  = 3'd0;
	localparam logic [2:0] REG_OV_LIMIT     = 3'd1;
	localparam logic [2:0] REG_UV_LIMIT     = 3'd2;
	localparam logic [2:0] REG_DROP_LIMIT   = 3'd3;
	localparam logic [2:0] REG_OC_DELAY     = 3'd4;
	localparam logic [2:0] REG_COOLDOWN     = 3'd5;
	localparam logic [2:0] REG_RETRY_WINDOW = 3'd6;
	localparam logic [2:0] REG_DEADTIME     = 3'd7;

	localparam int QUOT_BITS = 8;

	function automatic level_t level_for(input logic [3:0] mode, input logic on);
		level_t lvl;
		lvl = LVL_HIZ;
		unique case (mode[1:0])
			TYPE_PUSH_PULL:   lvl = (on ^ mode[2]) ? LVL_HIGH : LVL_LOW;
			TYPE_OPEN_DRAIN:  lvl = on ? LVL_LOW : LVL_HIZ;
			TYPE_OPEN_SOURCE: lvl = on ? LVL_HIGH : LVL_HIZ;
			TYPE_OFF:         lvl = LVL_HIZ;
		endcase
		return lvl;
	endfunction

endpackage

[hw/rtl/protected_half_bridge_output_core.sv]
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   source_mv .. delay_cycles, one tick per beat
// out       output     out_valid/out_stall drive_level .. overcurrent_warn, one per tick
// cfg       input      cfg_wr_en           cfg_index, cfg_data
//
// Each tick runs from one accepted beat to the next: the accepting edge latches it, PREP
// forms the switch drop and warnings, DIV runs the bit-serial drop quotient and DONE
// updates state and registers the result.
// The eight-step restoring divider runs in DIV.
// Reset is asynchronous and clears all protection and output state to zero.
// A new beat is taken only in idle, once the last tick has left DONE; the final step waits on out_stall.
module protected_half_bridge_output_core #(
	parameter int HOLD_LIMIT = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] source_mv,
	input  logic [15:0] output_mv,
	input  logic        target_on,
	input  logic        enable,
	input  logic        ext_fault_set,
	input  logic        ext_fault_clear,
	input  logic        clear_retry,
	input  logic        delay_load,
	input  logic [7:0]  delay_cycles,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  drive_level,
	output logic        real_on,
	output logic        fault_active,
	output logic        retry_pending,
	output logic [7:0]  fault_count,
	output logic        overvoltage_warn,
	output logic        undervoltage_warn,
	output logic        overcurrent_warn
);

	localparam logic [7:0] HOLD_MAX = 8'(HOLD_LIMIT);

	phbo_pkg::state_t state_q, state_d;

	logic [3:0]  mode_q;
	logic [15:0] ov_limit_q, uv_limit_q, drop_limit_q, cooldown_ticks_q, retry_window_q;
	logic [7:0]  oc_delay_q, deadtime_ticks_q;

	phbo_pkg::level_t drive_q;
	logic        real_q, fault_q, ext_fault_q, retry_flag_q;
	logic [7:0]  integ_q, hold_q, deadtime_q, tally_q;
	logic [15:0] cool_q, retry_cnt_q;

	logic [15:0] src_q, vout_q, rem_q;
	logic        target_q, en_q, ovw_q, uvw_q, ocw_q, integrate_q, sat_q;
	logic [7:0]  low_q;
	logic [2:0]  div_cnt_q;

	logic        out_valid_q;
	phbo_pkg::level_t out_drive_q;
	logic        out_real_q, out_fault_q, out_retry_q, out_ovw_q, out_uvw_q, out_ocw_q;
	logic [7:0]  out_tally_q;

	logic        in_fire, done_fire;
	logic [15:0] drop;
	logic [16:0] shifted;
	logic        ge;
	logic [7:0]  inc, integ_new, dt_dec;
	logic [8:0]  sum;
	logic        fault_cond;
	logic        fault_new, retry_new;
	logic [7:0]  tally_new;
	phbo_pkg::level_t lvl_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phbo_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		done_fire = 1'b0;
		unique case (state_q)
			phbo_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = phbo_pkg::ST_PREP;
			end
			phbo_pkg::ST_PREP: state_d = phbo_pkg::ST_DIV;
			phbo_pkg::ST_DIV: begin
				if (div_cnt_q == 3'(phbo_pkg::QUOT_BITS - 1)) state_d = phbo_pkg::ST_DONE;
			end
			phbo_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					done_fire = 1'b1;
					state_d = phbo_pkg::ST_IDLE;
				end
			end
		endcase
	end

	assign in_fire = in_valid && !in_stall;

	always_comb begin
		if (drive_q == phbo_pkg::LVL_HIGH && src_q > vout_q) drop = src_q - vout_q;
		else if (drive_q == phbo_pkg::LVL_LOW) drop = vout_q;
		else drop = 16'd0;
	end

	assign dt_dec  = (deadtime_q != 8'd0) ? deadtime_q - 8'd1 : 8'd0;
	assign shifted = {rem_q, low_q[7]};
	assign ge      = shifted >= {1'b0, drop_limit_q};

	always_comb begin
		inc = sat_q ? 8'hFF : low_q;
		sum = {1'b0, integ_q} + {1'b0, inc};
		if (integrate_q) integ_new = sum[8] ? 8'hFF : sum[7:0];
		else integ_new = (integ_q != 8'd0) ? integ_q - 8'd1 : 8'd0;
		fault_cond = ovw_q || uvw_q || (integ_new > oc_delay_q);
		fault_new = fault_q;
		retry_new = retry_flag_q;
		tally_new = tally_q;
		if (fault_cond) begin
			if (!fault_q && tally_q != 8'hFF) tally_new = tally_q + 8'd1;
			fault_new = 1'b1;
		end else if (cool_q != 16'd0) begin
		end else if (fault_q) begin
			fault_new = 1'b0;
			retry_new = 1'b1;
		end else if (retry_cnt_q != 16'd0) begin
		end else begin
			tally_new = 8'd0;
		end
	end

	assign lvl_new = phbo_pkg::level_for(mode_q, target_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			ov_limit_q <= '0;
			uv_limit_q <= '0;
			drop_limit_q <= '0;
			oc_delay_q <= '0;
			cooldown_ticks_q <= '0;
			retry_window_q <= '0;
			deadtime_ticks_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				phbo_pkg::REG_OUTPUT_MODE:  mode_q <= cfg_data[3:0];
				phbo_pkg::REG_OV_LIMIT:     ov_limit_q <= cfg_data;
				phbo_pkg::REG_UV_LIMIT:     uv_limit_q <= cfg_data;
				phbo_pkg::REG_DROP_LIMIT:   drop_limit_q <= cfg_data;
				phbo_pkg::REG_OC_DELAY:     oc_delay_q <= cfg_data[7:0];
				phbo_pkg::REG_COOLDOWN:     cooldown_ticks_q <= cfg_data;
				phbo_pkg::REG_RETRY_WINDOW: retry_window_q <= cfg_data;
				phbo_pkg::REG_DEADTIME:     deadtime_ticks_q <= cfg_data[7:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			src_q <= source_mv;
			vout_q <= output_mv;
			target_q <= target_on;
			en_q <= enable;
		end
		if (state_q == phbo_pkg::ST_PREP) begin
			ovw_q <= (ov_limit_q != 16'd0) && (src_q > ov_limit_q);
			uvw_q <= (uv_limit_q != 16'd0) && (src_q < uv_limit_q);
			ocw_q <= (drop_limit_q != 16'd0) && (drop > drop_limit_q);
			integrate_q <= (drop_limit_q != 16'd0) && (drop > drop_limit_q) && (dt_dec == 8'd0);
			sat_q <= {8'd0, drop[15:8]} >= drop_limit_q;
			rem_q <= {8'd0, drop[15:8]};
			low_q <= drop[7:0];
		end else if (state_q == phbo_pkg::ST_DIV) begin
			rem_q <= ge ? 16'(shifted - {1'b0, drop_limit_q}) : shifted[15:0];
			low_q <= {low_q[6:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= phbo_pkg::LVL_HIZ;
			real_q <= 1'b0;
			fault_q <= 1'b0;
			ext_fault_q <= 1'b0;
			retry_flag_q <= 1'b0;
			integ_q <= '0;
			hold_q <= '0;
			deadtime_q <= '0;
			tally_q <= '0;
			cool_q <= '0;
			retry_cnt_q <= '0;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
			out_drive_q <= phbo_pkg::LVL_HIZ;
			out_real_q <= 1'b0;
			out_fault_q <= 1'b0;
			out_retry_q <= 1'b0;
			out_tally_q <= '0;
			out_ovw_q <= 1'b0;
			out_uvw_q <= 1'b0;
			out_ocw_q <= 1'b0;
		end else begin
			if (in_fire) begin
				if (ext_fault_clear) ext_fault_q <= 1'b0;
				else if (ext_fault_set) ext_fault_q <= mode_q[3];
				if (clear_retry) retry_flag_q <= 1'b0;
				if (delay_load) hold_q <= (delay_cycles > HOLD_MAX) ? HOLD_MAX : delay_cycles;
			end
			if (state_q == phbo_pkg::ST_PREP) begin
				deadtime_q <= dt_dec;
				div_cnt_q <= '0;
			end
			if (state_q == phbo_pkg::ST_DIV) div_cnt_q <= div_cnt_q + 3'd1;
			if (done_fire) begin
				integ_q <= integ_new;
				if (fault_cond) begin
					if (cool_q == 16'd0) cool_q <= cooldown_ticks_q;
				end else if (cool_q != 16'd0) begin
					cool_q <= cool_q - 16'd1;
				end else if (fault_q) begin
					retry_cnt_q <= retry_window_q;
				end else if (retry_cnt_q != 16'd0) begin
					retry_cnt_q <= retry_cnt_q - 16'd1;
				end
				fault_q <= fault_new;
				retry_flag_q <= retry_new;
				tally_q <= tally_new;

				if (hold_q != 8'd0) begin
					hold_q <= hold_q - 8'd1;
					out_drive_q <= drive_q;
					out_real_q <= real_q;
				end else if (fault_new || ext_fault_q || !en_q) begin
					if (drive_q != phbo_pkg::LVL_HIZ) deadtime_q <= deadtime_ticks_q;
					drive_q <= phbo_pkg::LVL_HIZ;
					real_q <= 1'b0;
					out_drive_q <= phbo_pkg::LVL_HIZ;
					out_real_q <= 1'b0;
				end else begin
					if (drive_q != lvl_new) deadtime_q <= deadtime_ticks_q;
					drive_q <= lvl_new;
					real_q <= target_q;
					out_drive_q <= lvl_new;
					out_real_q <= target_q;
				end
				out_fault_q <= fault_new || ext_fault_q;
				out_retry_q <= retry_new;
				out_tally_q <= tally_new;
				out_ovw_q <= ovw_q;
				out_uvw_q <= uvw_q;
				out_ocw_q <= ocw_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign drive_level = out_drive_q;
	assign real_on = out_real_q;
	assign fault_active = out_fault_q;
	assign retry_pending = out_retry_q;
	assign fault_count = out_tally_q;
	assign overvoltage_warn = out_ovw_q;
	assign undervoltage_warn = out_uvw_q;
	assign overcurrent_warn = out_ocw_q;

	a_level_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (drive_level == phbo_pkg::LVL_HIZ || drive_level == phbo_pkg::LVL_LOW
			|| drive_level == phbo_pkg::LVL_HIGH))
		else $error("drive level code out of range");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == phbo_pkg::ST_PREP |=> state_q == phbo_pkg::ST_DIV && div_cnt_q == 3'd0)
		else $error("divider did not start from step zero");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == phbo_pkg::ST_DIV || state_q == phbo_pkg::ST_DONE) && !sat_q
		|-> rem_q < drop_limit_q)
		else $error("divider remainder not below divisor");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire |=> out_valid_q && state_q == phbo_pkg::ST_IDLE)
		else $error("finished tick did not reach the output register");

endmodule
